/* rtl/art_pkg.sv */
// Package for the address region table: item layouts, status and mode codes,
// table entry and request/result structures.
// No dependencies; used by art_engine and address_region_table_core.
package art_pkg;

	// Default table geometry.
	localparam int MAX_RANGES_DEF = 64;
	localparam int PAGE_SHIFT_DEF = 12;

	// Field widths fixed by the item formats.
	localparam int ADDR_W    = 64;
	localparam int TAG_W     = 28;
	localparam int STATUS_W  = 4;
	localparam int COUNT_W   = 7;
	localparam int MODE_W    = 2;
	localparam int ALIGN_W   = 6;
	localparam int IN_DATA_W = 232;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W = 8;

	// Operation modes.
	localparam logic [MODE_W-1:0] MODE_ADD       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUB       = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE_UP   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_FREE_DOWN = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 4'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 4'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT     = 4'd3;
	localparam logic [STATUS_W-1:0] ST_BUDGET    = 4'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd5;
	localparam logic [STATUS_W-1:0] ST_FULL      = 4'd6;
	localparam logic [STATUS_W-1:0] ST_OVERLAP   = 4'd7;
	localparam logic [STATUS_W-1:0] ST_CLIPPED   = 4'd8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LIMIT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BUDGET = 8'd1;

	// One held range.
	typedef struct packed {
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] last;
		logic [TAG_W-1:0]  tag;
	} art_ent_t;

	// One request handed to the engine.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ADDR_W-1:0]  first;
		logic [ADDR_W-1:0]  last;
		logic [TAG_W-1:0]   tag;
		logic [ADDR_W-1:0]  want_size;
		logic [ALIGN_W-1:0] align_log2;
		logic               overlap_ok;
	} art_req_t;

	// One result returned by the engine.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   found_address;
		logic [COUNT_W-1:0]  entry_count;
	} art_res_t;

endpackage

/* rtl/art_engine.sv */
// Sequencer and table memory of the address region table.
// Holds the sorted ranges in one synchronous memory; depends on art_pkg.
// Every table read is registered and its data is used in the next cycle.
module art_engine import art_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  art_req_t          req,
	input  logic [ADDR_W-1:0] addr_limit,
	input  logic [ADDR_W-1:0] size_budget,
	output logic              res_valid,
	input  logic              res_ready,
	output art_res_t          res
);

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
	localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

	localparam logic [5:0] S_IDLE    = 6'd0;
	localparam logic [5:0] S_ADD_A   = 6'd1;
	localparam logic [5:0] S_ADD_B   = 6'd2;
	localparam logic [5:0] S_ADD_C   = 6'd3;
	localparam logic [5:0] S_ADD_D   = 6'd4;
	localparam logic [5:0] S_POS     = 6'd5;
	localparam logic [5:0] S_POS_CK  = 6'd6;
	localparam logic [5:0] S_PS_RD   = 6'd7;
	localparam logic [5:0] S_PS_CK   = 6'd8;
	localparam logic [5:0] S_SHI_RD  = 6'd9;
	localparam logic [5:0] S_SHI_WR  = 6'd10;
	localparam logic [5:0] S_INS     = 6'd11;
	localparam logic [5:0] S_MG_INIT = 6'd12;
	localparam logic [5:0] S_MG_LD   = 6'd13;
	localparam logic [5:0] S_MG_LOOP = 6'd14;
	localparam logic [5:0] S_MG_CK   = 6'd15;
	localparam logic [5:0] S_RM_RD   = 6'd16;
	localparam logic [5:0] S_RM_WR   = 6'd17;
	localparam logic [5:0] S_SB_A    = 6'd18;
	localparam logic [5:0] S_SB_RD   = 6'd19;
	localparam logic [5:0] S_SB_CK   = 6'd20;
	localparam logic [5:0] S_SB_X    = 6'd21;
	localparam logic [5:0] S_FD_A    = 6'd22;
	localparam logic [5:0] S_FD_B    = 6'd23;
	localparam logic [5:0] S_FD_C    = 6'd24;
	localparam logic [5:0] S_FU_A    = 6'd25;
	localparam logic [5:0] S_FU_B    = 6'd26;
	localparam logic [5:0] S_FDN_A   = 6'd27;
	localparam logic [5:0] S_FDN_B   = 6'd28;
	localparam logic [5:0] S_HT_RD   = 6'd29;
	localparam logic [5:0] S_HT_CK   = 6'd30;
	localparam logic [5:0] S_FIN     = 6'd31;

	// Table memory and its registered read port.
	art_ent_t mem [MAX_RANGES];
	art_ent_t rd_q;
	logic          re, we;
	logic [IW-1:0] raddr, waddr;
	art_ent_t      wdata;

	logic [5:0]          state_q, ret_q;
	logic [MODE_W-1:0]   mode_q;
	logic [ADDR_W-1:0]   a_q, b_q, want_q, size_q, rem_q, mask_q, pt_q, hl_q, hh_q;
	logic [TAG_W-1:0]    tag_q;
	logic [ALIGN_W-1:0]  align_q;
	logic                ovl_q, clipped_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   found_q, total_q;
	logic [CW-1:0]       held_q, idx_q, pos_q, rm_q;
	art_ent_t            cur_q;

	logic [CW-1:0]     idx_p1, idx_m1, rm_p1, held_m1;
	logic [ADDR_W-1:0] up_page;
	logic              touch, hit;
	logic [ADDR_W-1:0] held_ext;

	assign idx_p1  = idx_q + CW'(1);
	assign idx_m1  = idx_q - CW'(1);
	assign rm_p1   = rm_q + CW'(1);
	assign held_m1 = held_q - CW'(1);

	// Page adjacency of the current range's end and the next range's start.
	assign up_page = (cur_q.last >> PAGE_SHIFT) + ADDR_W'((cur_q.last & PAGE_MASK) != '0);
	assign touch   = up_page >= (rd_q.first >> PAGE_SHIFT);
	assign hit     = (rd_q.first <= hh_q) && (hl_q <= rd_q.last);

	// Memory port control.
	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		raddr = idx_q[IW-1:0];
		waddr = idx_q[IW-1:0];
		wdata = rd_q;
		case (state_q)
			S_POS: begin
				re    = (held_q != '0);
				raddr = held_m1[IW-1:0];
			end
			S_PS_RD, S_HT_RD, S_SB_RD: begin
				re = (idx_q < held_q);
			end
			S_SHI_RD: begin
				re    = (idx_q > pos_q);
				raddr = idx_m1[IW-1:0];
			end
			S_SHI_WR: begin
				we = 1'b1;
			end
			S_INS: begin
				we    = 1'b1;
				waddr = pos_q[IW-1:0];
				wdata = '{first: a_q, last: b_q, tag: tag_q};
			end
			S_MG_INIT: begin
				re = 1'b1;
			end
			S_MG_LOOP: begin
				re    = (idx_p1 < held_q);
				we    = !(idx_p1 < held_q);
				raddr = idx_p1[IW-1:0];
				wdata = cur_q;
			end
			S_MG_CK: begin
				we    = !((rd_q.tag == cur_q.tag) && touch);
				wdata = cur_q;
			end
			S_RM_RD: begin
				re    = (rm_p1 < held_q);
				raddr = rm_p1[IW-1:0];
			end
			S_RM_WR: begin
				we    = 1'b1;
				waddr = rm_q[IW-1:0];
			end
			S_SB_X: begin
				we    = !((cur_q.first == a_q) && (cur_q.last == b_q));
				waddr = pos_q[IW-1:0];
				wdata = cur_q;
				if (cur_q.first == a_q) begin
					wdata.first = b_q + 64'd1;
				end else begin
					wdata.last = a_q - 64'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// Operation sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			held_q   <= '0;
			total_q  <= '0;
			status_q <= ST_OK;
			found_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q    <= req.mode;
						a_q       <= req.first;
						b_q       <= req.last;
						tag_q     <= req.tag;
						want_q    <= req.want_size;
						align_q   <= req.align_log2;
						ovl_q     <= req.overlap_ok;
						clipped_q <= 1'b0;
						found_q   <= '0;
						case (req.mode)
							MODE_ADD: state_q <= S_ADD_A;
							MODE_SUB: state_q <= S_SB_A;
							default:  state_q <= S_FD_A;
						endcase
					end
				end
				// Add: validity and limit clip.
				S_ADD_A: begin
					if (a_q > b_q) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else if (a_q >= addr_limit) begin
						status_q <= ST_LIMIT;
						state_q  <= S_FIN;
					end else begin
						if (b_q >= addr_limit) begin
							b_q       <= addr_limit - 64'd1;
							clipped_q <= 1'b1;
						end
						state_q <= S_ADD_B;
					end
				end
				// Add: budget room and size.
				S_ADD_B: begin
					if (total_q >= size_budget) begin
						status_q <= ST_BUDGET;
						state_q  <= S_FIN;
					end else begin
						size_q  <= b_q - a_q + 64'd1;
						rem_q   <= size_budget - total_q;
						state_q <= S_ADD_C;
					end
				end
				S_ADD_C: begin
					if (size_q > rem_q) begin
						b_q       <= a_q + rem_q - 64'd1;
						size_q    <= rem_q;
						clipped_q <= 1'b1;
					end
					state_q <= S_ADD_D;
				end
				S_ADD_D: begin
					if (a_q == b_q) begin
						status_q <= ST_EMPTY;
						state_q  <= S_FIN;
					end else if (held_q >= CW'(MAX_RANGES)) begin
						idx_q   <= '0;
						state_q <= S_MG_INIT;
					end else begin
						state_q <= S_POS;
					end
				end
				// Insert position: append or scan for the first end at or above.
				S_POS: begin
					if (held_q == '0) begin
						pos_q   <= '0;
						state_q <= S_INS;
					end else begin
						state_q <= S_POS_CK;
					end
				end
				S_POS_CK: begin
					if (rd_q.last < a_q) begin
						pos_q   <= held_q;
						state_q <= S_INS;
					end else begin
						idx_q   <= '0;
						state_q <= S_PS_RD;
					end
				end
				S_PS_RD: begin
					state_q <= S_PS_CK;
				end
				S_PS_CK: begin
					if (rd_q.last >= a_q) begin
						pos_q <= idx_q;
						if (!ovl_q && !(b_q < rd_q.first)) begin
							status_q <= ST_OVERLAP;
							state_q  <= S_FIN;
						end else begin
							idx_q   <= held_q;
							state_q <= S_SHI_RD;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_PS_RD;
					end
				end
				// Open a gap by moving entries up one place.
				S_SHI_RD: begin
					state_q <= (idx_q > pos_q) ? S_SHI_WR : S_INS;
				end
				S_SHI_WR: begin
					idx_q   <= idx_m1;
					state_q <= S_SHI_RD;
				end
				S_INS: begin
					held_q   <= held_q + CW'(1);
					total_q  <= total_q + size_q;
					status_q <= clipped_q ? ST_CLIPPED : ST_OK;
					state_q  <= S_FIN;
				end
				// Merge neighbours with equal tags whose pages touch.
				S_MG_INIT: begin
					state_q <= S_MG_LD;
				end
				S_MG_LD: begin
					cur_q   <= rd_q;
					state_q <= S_MG_LOOP;
				end
				S_MG_LOOP: begin
					if (idx_p1 < held_q) begin
						state_q <= S_MG_CK;
					end else if (held_q >= CW'(MAX_RANGES)) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_POS;
					end
				end
				S_MG_CK: begin
					if ((rd_q.tag == cur_q.tag) && touch) begin
						if (rd_q.last > cur_q.last) begin
							cur_q.last <= rd_q.last;
						end
						rm_q    <= idx_p1;
						ret_q   <= S_MG_LOOP;
						state_q <= S_RM_RD;
					end else begin
						cur_q   <= rd_q;
						idx_q   <= idx_p1;
						state_q <= S_MG_LOOP;
					end
				end
				// Remove one entry by moving the ones above it down.
				S_RM_RD: begin
					if (rm_p1 < held_q) begin
						state_q <= S_RM_WR;
					end else begin
						held_q  <= held_m1;
						state_q <= ret_q;
					end
				end
				S_RM_WR: begin
					rm_q    <= rm_p1;
					state_q <= S_RM_RD;
				end
				// Subtract: find the range that contains the request.
				S_SB_A: begin
					if (a_q > b_q) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else begin
						idx_q   <= '0;
						state_q <= S_SB_RD;
					end
				end
				S_SB_RD: begin
					if (idx_q < held_q) begin
						state_q <= S_SB_CK;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end
				end
				S_SB_CK: begin
					if ((rd_q.first <= a_q) && (rd_q.last >= b_q)) begin
						cur_q   <= rd_q;
						pos_q   <= idx_q;
						state_q <= S_SB_X;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_SB_RD;
					end
				end
				S_SB_X: begin
					status_q <= ST_OK;
					if ((cur_q.first == a_q) && (cur_q.last == b_q)) begin
						rm_q    <= pos_q;
						ret_q   <= S_FIN;
						state_q <= S_RM_RD;
					end else if ((cur_q.first == a_q) || (cur_q.last == b_q)) begin
						state_q <= S_FIN;
					end else begin
						// Split: the tail goes back in as a normal add without overlap.
						a_q     <= b_q + 64'd1;
						b_q     <= cur_q.last;
						tag_q   <= cur_q.tag;
						ovl_q   <= 1'b0;
						state_q <= S_ADD_A;
					end
				end
				// Free search: mask and rounded size.
				S_FD_A: begin
					mask_q  <= ~(ALL_ONES << align_q);
					state_q <= S_FD_B;
				end
				S_FD_B: begin
					if (want_q > ~mask_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						size_q  <= (want_q + mask_q) & ~mask_q;
						state_q <= S_FD_C;
					end
				end
				S_FD_C: begin
					if (size_q == '0) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else if (mode_q == MODE_FREE_UP) begin
						pt_q    <= a_q;
						state_q <= S_FU_A;
					end else begin
						pt_q    <= b_q;
						state_q <= S_FDN_A;
					end
				end
				// Upward candidate from the running start address.
				S_FU_A: begin
					if (pt_q > ~mask_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						pt_q    <= (pt_q + mask_q) & ~mask_q;
						state_q <= S_FU_B;
					end
				end
				S_FU_B: begin
					if ((pt_q > b_q) || ((b_q - pt_q) < (size_q - 64'd1))) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						hl_q    <= pt_q;
						hh_q    <= pt_q + size_q - 64'd1;
						idx_q   <= '0;
						state_q <= S_HT_RD;
					end
				end
				// Downward candidate below the running end address.
				S_FDN_A: begin
					if (pt_q <= size_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						hl_q    <= (pt_q - size_q - 64'd1) & ~mask_q;
						state_q <= S_FDN_B;
					end
				end
				S_FDN_B: begin
					if (hl_q < a_q) begin
						status_q <= ST_NOT_FOUND;
						state_q  <= S_FIN;
					end else begin
						hh_q    <= hl_q + size_q - 64'd1;
						idx_q   <= '0;
						state_q <= S_HT_RD;
					end
				end
				// Scan for the first held range that overlaps the candidate.
				S_HT_RD: begin
					if (idx_q < held_q) begin
						state_q <= S_HT_CK;
					end else begin
						found_q  <= hl_q;
						status_q <= ST_OK;
						state_q  <= S_FIN;
					end
				end
				S_HT_CK: begin
					if (!hit) begin
						idx_q   <= idx_p1;
						state_q <= S_HT_RD;
					end else if (mode_q == MODE_FREE_UP) begin
						if (rd_q.last == ALL_ONES) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_FIN;
						end else begin
							pt_q    <= rd_q.last + 64'd1;
							state_q <= S_FU_A;
						end
					end else begin
						if (rd_q.first == '0) begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_FIN;
						end else begin
							pt_q    <= rd_q.first - 64'd1;
							state_q <= S_FDN_A;
						end
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result and handshake.
	assign held_ext          = ADDR_W'(held_q);
	assign req_ready         = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_FIN);
	assign res.status        = status_q;
	assign res.found_address = (status_q == ST_OK) ? found_q : '0;
	assign res.entry_count   = held_ext[COUNT_W-1:0];

`ifndef SYNTH
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_RANGES))
		else $error("held range count exceeds table depth");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("added size total decreased");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != ST_OK) |-> res.found_address == '0)
		else $error("hole address reported with a failing status");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !re)
		else $error("table read and write in the same cycle");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status_q <= ST_CLIPPED)
		else $error("undefined status code in result");
`endif

endmodule

/* rtl/address_region_table_core.sv */
// Top level of the address region table: stream ports, configuration
// registers and the result register. Depends on art_pkg and art_engine.
//
// Keeps up to MAX_RANGES sorted inclusive address ranges in one single-port
// table memory and answers one result item for each request item. Every table
// read gives its address first and then returns registered data, so the time
// per item is set by how many entries the operation walks: a rejected add ends
// early, a plain add or subtract depends on the entries it scans and moves, an
// add to a full table first merges neighbours, and a free search scans the held
// ranges again for every candidate hole it tries. A new request is taken as soon
// as the previous result has been handed to the output register, which holds it
// until the consumer takes it. No clearing pass is needed after reset.
// Configuration must be written only while no item is in work; the block
// itself does not enforce this.
module address_region_table_core import art_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Request items.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// range_first[63:0], range_last[127:64], kind[130:128], sub_kind[138:131],
	// eager_flag[139], label_id[155:140], want_size[219:156], align_log2[225:220],
	// overlap_ok[226], zero fill[231:227]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]     s_axis_tuser,
	// Result items.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// status[3:0], found_address[67:4], entry_count[74:68], zero fill[79:75]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [ADDR_W-1:0]     cfg_data
);

	logic [ADDR_W-1:0] limit_q, budget_q;
	art_req_t          req;
	art_res_t          res;
	logic              res_valid, res_ready;
	logic              out_valid_q;
	art_res_t          out_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= '1;
			budget_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ADDR_LIMIT:  limit_q  <= cfg_data;
				CFG_SIZE_BUDGET: budget_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request unpacking.
	assign req.mode       = s_axis_tuser;
	assign req.first      = s_axis_tdata[63:0];
	assign req.last       = s_axis_tdata[127:64];
	assign req.tag        = {s_axis_tdata[155:140], s_axis_tdata[139],
	                         s_axis_tdata[138:131], s_axis_tdata[130:128]};
	assign req.want_size  = s_axis_tdata[219:156];
	assign req.align_log2 = s_axis_tdata[225:220];
	assign req.overlap_ok = s_axis_tdata[226];

	art_engine #(
		.MAX_RANGES (MAX_RANGES),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req         (req),
		.addr_limit  (limit_q),
		.size_budget (budget_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: takes a result whenever it is empty or being emptied.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.entry_count, out_q.found_address, out_q.status};

endmodule
